FILE: hw/rtl/ecu_csd_pkg.sv
// shared types, constants and descriptor tables for the can broadcast signal decoder
// used by ecu_csd_ctrl, ecu_csd_dp and ecu_can_broadcast_signal_decoder; no dependencies
package ecu_csd_pkg;

    localparam int unsigned ID_W        = 11;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned VALUE_W     = 20;
    localparam int unsigned FRAME_COUNT = 11;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd512;

    // reciprocal of three, scaled by two to the RECIP_SHIFT
    localparam int unsigned   RECIP_SHIFT = 21;
    localparam logic [19:0]   RECIP_3     = 20'hAAAAB;
    localparam logic [20:0]   SUB_OFFSET  = 21'd40;

    typedef enum logic [2:0] {
        KIND_U8  = 3'd0,
        KIND_I8  = 3'd1,
        KIND_U16 = 3'd2,
        KIND_I16 = 3'd3,
        KIND_BIT = 3'd4
    } sig_kind_t;

    // tail_end: end byte of the next descriptor in the frame that needs the
    // fewest bytes, zero when this is the final descriptor of the frame
    typedef struct packed {
        sig_kind_t   kind;
        logic [5:0]  pos;
        logic [5:0]  mul;
        logic        div3;
        logic        sub40;
        logic [3:0]  tail_end;
    } sig_desc_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] idx;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              frame_hit;
        logic [SLOT_W-1:0] slot;
        logic              pipe_busy;
    } dp_status_t;

    function automatic sig_desc_t mk(sig_kind_t k, logic [5:0] p, logic [5:0] m,
                                     logic d3, logic s40, logic [3:0] t);
        sig_desc_t d;
        d.kind     = k;
        d.pos      = p;
        d.mul      = m;
        d.div3     = d3;
        d.sub40    = s40;
        d.tail_end = t;
        return d;
    endfunction

    // fixed signal descriptor table
    function automatic sig_desc_t sig_desc(logic [IDX_W-1:0] idx);
        sig_desc_t d;
        unique case (idx)
            // frame 0
            6'd0:  d = mk(KIND_U16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd1:  d = mk(KIND_U16, 6'd2,  6'd1,  1'b0, 1'b0, 4'd5);
            6'd2:  d = mk(KIND_BIT, 6'd32, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd3:  d = mk(KIND_BIT, 6'd33, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd4:  d = mk(KIND_BIT, 6'd34, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd5:  d = mk(KIND_BIT, 6'd35, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd6:  d = mk(KIND_BIT, 6'd36, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd7:  d = mk(KIND_BIT, 6'd37, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd8:  d = mk(KIND_BIT, 6'd38, 6'd1,  1'b0, 1'b0, 4'd5);
            6'd9:  d = mk(KIND_BIT, 6'd39, 6'd1,  1'b0, 1'b0, 4'd6);
            6'd10: d = mk(KIND_U8,  6'd5,  6'd1,  1'b0, 1'b0, 4'd8);
            6'd11: d = mk(KIND_U16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 1
            6'd12: d = mk(KIND_U16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd13: d = mk(KIND_I16, 6'd2,  6'd2,  1'b0, 1'b0, 4'd5);
            6'd14: d = mk(KIND_U8,  6'd4,  6'd50, 1'b0, 1'b0, 4'd6);
            6'd15: d = mk(KIND_U8,  6'd5,  6'd50, 1'b0, 1'b0, 4'd7);
            6'd16: d = mk(KIND_U8,  6'd6,  6'd1,  1'b0, 1'b0, 4'd8);
            6'd17: d = mk(KIND_U8,  6'd7,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 2
            6'd18: d = mk(KIND_I16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd19: d = mk(KIND_I16, 6'd2,  6'd1,  1'b0, 1'b0, 4'd6);
            6'd20: d = mk(KIND_I16, 6'd4,  6'd1,  1'b0, 1'b0, 4'd8);
            6'd21: d = mk(KIND_I16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 3
            6'd22: d = mk(KIND_U16, 6'd0,  6'd1,  1'b1, 1'b0, 4'd3);
            6'd23: d = mk(KIND_U8,  6'd2,  6'd1,  1'b0, 1'b1, 4'd4);
            6'd24: d = mk(KIND_U8,  6'd3,  6'd1,  1'b0, 1'b1, 4'd5);
            6'd25: d = mk(KIND_U8,  6'd4,  6'd1,  1'b0, 1'b1, 4'd6);
            6'd26: d = mk(KIND_U8,  6'd5,  6'd1,  1'b0, 1'b1, 4'd7);
            6'd27: d = mk(KIND_U8,  6'd6,  6'd1,  1'b0, 1'b1, 4'd8);
            6'd28: d = mk(KIND_U8,  6'd7,  6'd50, 1'b0, 1'b0, 4'd0);
            // frame 4
            6'd29: d = mk(KIND_U16, 6'd2,  6'd1,  1'b1, 1'b0, 4'd5);
            6'd30: d = mk(KIND_U8,  6'd4,  6'd1,  1'b0, 1'b1, 4'd6);
            6'd31: d = mk(KIND_U8,  6'd5,  6'd1,  1'b0, 1'b1, 4'd8);
            6'd32: d = mk(KIND_U16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 5
            6'd33: d = mk(KIND_U16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd34: d = mk(KIND_U16, 6'd2,  6'd1,  1'b0, 1'b0, 4'd6);
            6'd35: d = mk(KIND_U16, 6'd4,  6'd10, 1'b1, 1'b0, 4'd8);
            6'd36: d = mk(KIND_U16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 6
            6'd37: d = mk(KIND_U16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd38: d = mk(KIND_U16, 6'd2,  6'd5,  1'b0, 1'b0, 4'd6);
            6'd39: d = mk(KIND_I16, 6'd4,  6'd1,  1'b0, 1'b0, 4'd8);
            6'd40: d = mk(KIND_I16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 7
            6'd41: d = mk(KIND_U16, 6'd0,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd42: d = mk(KIND_U16, 6'd2,  6'd1,  1'b0, 1'b0, 4'd6);
            6'd43: d = mk(KIND_U16, 6'd4,  6'd1,  1'b1, 1'b0, 4'd8);
            6'd44: d = mk(KIND_U16, 6'd6,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 8
            6'd45: d = mk(KIND_I8,  6'd0,  6'd1,  1'b0, 1'b0, 4'd2);
            6'd46: d = mk(KIND_I8,  6'd1,  6'd1,  1'b0, 1'b0, 4'd3);
            6'd47: d = mk(KIND_I8,  6'd2,  6'd1,  1'b0, 1'b0, 4'd4);
            6'd48: d = mk(KIND_I8,  6'd3,  6'd1,  1'b0, 1'b0, 4'd5);
            6'd49: d = mk(KIND_I8,  6'd4,  6'd1,  1'b0, 1'b0, 4'd6);
            6'd50: d = mk(KIND_I8,  6'd5,  6'd1,  1'b0, 1'b0, 4'd7);
            6'd51: d = mk(KIND_I8,  6'd6,  6'd1,  1'b0, 1'b0, 4'd8);
            6'd52: d = mk(KIND_I8,  6'd7,  6'd1,  1'b0, 1'b0, 4'd0);
            // frame 9
            6'd53: d = mk(KIND_U8,  6'd0,  6'd5,  1'b0, 1'b0, 4'd2);
            6'd54: d = mk(KIND_U8,  6'd1,  6'd5,  1'b0, 1'b0, 4'd3);
            6'd55: d = mk(KIND_U8,  6'd2,  6'd5,  1'b0, 1'b0, 4'd4);
            6'd56: d = mk(KIND_U8,  6'd3,  6'd5,  1'b0, 1'b0, 4'd5);
            6'd57: d = mk(KIND_U8,  6'd4,  6'd5,  1'b0, 1'b0, 4'd6);
            6'd58: d = mk(KIND_U8,  6'd5,  6'd5,  1'b0, 1'b0, 4'd7);
            6'd59: d = mk(KIND_U8,  6'd6,  6'd5,  1'b0, 1'b0, 4'd8);
            6'd60: d = mk(KIND_U8,  6'd7,  6'd5,  1'b0, 1'b0, 4'd0);
            // frame 10
            6'd61: d = mk(KIND_I8,  6'd0,  6'd1,  1'b0, 1'b0, 4'd2);
            6'd62: d = mk(KIND_I8,  6'd1,  6'd1,  1'b0, 1'b0, 4'd3);
            6'd63: d = mk(KIND_I8,  6'd2,  6'd1,  1'b0, 1'b0, 4'd0);
            default: d = mk(KIND_U8, 6'd0, 6'd1, 1'b0, 1'b0, 4'd0);
        endcase
        return d;
    endfunction

    // first descriptor of each frame slot
    function automatic logic [IDX_W-1:0] frame_first(logic [SLOT_W-1:0] slot);
        logic [IDX_W-1:0] f;
        unique case (slot)
            4'd0:    f = 6'd0;
            4'd1:    f = 6'd12;
            4'd2:    f = 6'd18;
            4'd3:    f = 6'd22;
            4'd4:    f = 6'd29;
            4'd5:    f = 6'd33;
            4'd6:    f = 6'd37;
            4'd7:    f = 6'd41;
            4'd8:    f = 6'd45;
            4'd9:    f = 6'd53;
            4'd10:   f = 6'd61;
            default: f = 6'd0;
        endcase
        return f;
    endfunction

    // last descriptor of each frame slot
    function automatic logic [IDX_W-1:0] frame_last(logic [SLOT_W-1:0] slot);
        logic [IDX_W-1:0] l;
        unique case (slot)
            4'd0:    l = 6'd11;
            4'd1:    l = 6'd17;
            4'd2:    l = 6'd21;
            4'd3:    l = 6'd28;
            4'd4:    l = 6'd32;
            4'd5:    l = 6'd36;
            4'd6:    l = 6'd40;
            4'd7:    l = 6'd44;
            4'd8:    l = 6'd52;
            4'd9:    l = 6'd60;
            4'd10:   l = 6'd63;
            default: l = 6'd0;
        endcase
        return l;
    endfunction

endpackage

FILE: hw/rtl/ecu_csd_ctrl.sv
// controller: walks the descriptor range of a matched frame, one per cycle
// depends on ecu_csd_pkg for command/status structs and frame range tables
module ecu_csd_ctrl
    import ecu_csd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } ctl_state_t;

    ctl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;

    // state and descriptor counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        cmd.load      = 1'b0;
        cmd.issue     = 1'b0;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start && status.frame_hit)
                begin
                    idx_next      = frame_first(status.slot);
                    last_idx_next = frame_last(status.slot);
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: hw/rtl/ecu_csd_dp.sv
// datapath: frame capture, identifier window, byte extraction and scaling pipeline
// depends on ecu_csd_pkg for the descriptor table, structs and constants
module ecu_csd_dp
    import ecu_csd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_cmd_t                  cmd,
    output dp_status_t                status,
    input  logic                      cfg_we,
    input  logic [ID_W-1:0]           cfg_data,
    input  logic [ID_W-1:0]           can_id,
    input  logic [LEN_W-1:0]          frame_length,
    input  logic [63:0]               frame_bytes,
    output logic                      result_strobe,
    output logic [IDX_W-1:0]          signal_index,
    output logic signed [VALUE_W-1:0] signal_value,
    output logic                      last_of_frame
);

    logic [ID_W-1:0]  base_id_reg;
    logic [LEN_W-1:0] len_reg;
    logic [63:0]      bytes_reg;

    // base identifier register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg <= BASE_ID_RESET;
        end
        else if (cfg_we)
        begin
            base_id_reg <= cfg_data;
        end
    end

    // frame capture on the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg   <= frame_length;
            bytes_reg <= frame_bytes;
        end
    end

    // identifier window, no wraparound past the top identifier
    logic [ID_W:0] id_diff;
    assign id_diff = {1'b0, can_id} - {1'b0, base_id_reg};

    assign status.frame_hit = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(FRAME_COUNT));
    assign status.slot      = id_diff[SLOT_W-1:0];

    // stage 0: descriptor lookup and raw field extraction
    sig_desc_t          desc;
    logic [2:0]         byte_pos;
    logic [3:0]         need;
    logic [3:0]         end_pos;
    logic               present;
    logic [15:0]        window;
    logic [7:0]         lo;
    logic signed [16:0] raw;
    logic signed [23:0] prod_full;
    logic               last0;

    always_comb
    begin
        desc     = sig_desc(cmd.idx);
        byte_pos = (desc.kind == KIND_BIT) ? desc.pos[5:3] : desc.pos[2:0];
        need     = ((desc.kind == KIND_U16) || (desc.kind == KIND_I16)) ? 4'd2 : 4'd1;
        end_pos  = {1'b0, byte_pos} + need;
        present  = (end_pos <= len_reg);
        window   = 16'(bytes_reg >> {byte_pos, 3'b000});
        lo       = window[7:0];
        unique case (desc.kind)
            KIND_U8:  raw = {9'b0, lo};
            KIND_I8:  raw = {{9{lo[7]}}, lo};
            KIND_U16: raw = {1'b0, window};
            KIND_I16: raw = {window[15], window};
            KIND_BIT: raw = {16'b0, lo[desc.pos[2:0]]};
            default:  raw = '0;
        endcase
        prod_full = raw * $signed({1'b0, desc.mul});
        last0     = (desc.tail_end == 4'd0) || (desc.tail_end > len_reg);
    end

    // stage 1: scaled product
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [20:0]       s1_prod_reg;
    logic              s1_div3_reg;
    logic              s1_sub40_reg;
    logic              s1_last_reg;

    // stage 2: magnitude times reciprocal
    logic              s2_valid_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [40:0]       s2_scaled_reg;
    logic [40:0]       s2_scaled_next;
    logic              s2_neg_reg;
    logic              s2_sub40_reg;
    logic              s2_last_reg;

    logic              result_strobe_reg;
    logic [IDX_W-1:0]  signal_index_reg;
    logic [VALUE_W-1:0] signal_value_reg;
    logic [VALUE_W-1:0] signal_value_next;
    logic              last_of_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= cmd.issue && present;
            s2_valid_reg      <= s1_valid_reg;
            result_strobe_reg <= s2_valid_reg;
        end
    end

    // sign and magnitude, divide by three through the reciprocal
    logic [20:0] neg_prod;
    logic [19:0] mag;
    logic [39:0] recip_prod;

    always_comb
    begin
        neg_prod       = 21'd0 - s1_prod_reg;
        mag            = s1_prod_reg[20] ? neg_prod[19:0] : s1_prod_reg[19:0];
        recip_prod     = mag * RECIP_3;
        s2_scaled_next = s1_div3_reg ? {1'b0, recip_prod} : {mag, 21'b0};
    end

    // restore sign and apply the offset
    logic [19:0] quo;
    logic [20:0] quo_signed;
    logic [20:0] val_full;

    always_comb
    begin
        quo               = s2_scaled_reg[40:RECIP_SHIFT];
        quo_signed        = s2_neg_reg ? (21'd0 - {1'b0, quo}) : {1'b0, quo};
        val_full          = s2_sub40_reg ? (quo_signed - SUB_OFFSET) : quo_signed;
        signal_value_next = val_full[VALUE_W-1:0];
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_idx_reg        <= cmd.idx;
        s1_prod_reg       <= prod_full[20:0];
        s1_div3_reg       <= desc.div3;
        s1_sub40_reg      <= desc.sub40;
        s1_last_reg       <= last0;
        s2_idx_reg        <= s1_idx_reg;
        s2_scaled_reg     <= s2_scaled_next;
        s2_neg_reg        <= s1_prod_reg[20];
        s2_sub40_reg      <= s1_sub40_reg;
        s2_last_reg       <= s1_last_reg;
        signal_index_reg  <= s2_idx_reg;
        signal_value_reg  <= signal_value_next;
        last_of_frame_reg <= s2_last_reg;
    end

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

    assign result_strobe = result_strobe_reg;
    assign signal_index  = signal_index_reg;
    assign signal_value  = signal_value_reg;
    assign last_of_frame = last_of_frame_reg;

endmodule

FILE: hw/rtl/ecu_can_broadcast_signal_decoder.sv
// top level of the can broadcast signal decoder: busy rises the cycle after a matching
// frame is taken; the first result follows that beat through the run state and the
// s1, s2 and output registers, then one per cycle, with a gap for each field past the length
// a matching frame holds busy through the one-per-cycle descriptor walk and the drain of
// the three-stage scaling pipeline; a frame outside the identifier window gives nothing
// reset clears control and sets base_id to 512; results cannot be held off by the receiver
module ecu_can_broadcast_signal_decoder
    import ecu_csd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ID_W-1:0]           can_id,
    input  logic [LEN_W-1:0]          frame_length,
    input  logic [7:0]                data_byte_0,
    input  logic [7:0]                data_byte_1,
    input  logic [7:0]                data_byte_2,
    input  logic [7:0]                data_byte_3,
    input  logic [7:0]                data_byte_4,
    input  logic [7:0]                data_byte_5,
    input  logic [7:0]                data_byte_6,
    input  logic [7:0]                data_byte_7,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ID_W-1:0]           cfg_data,
    output logic                      result_strobe,
    output logic [IDX_W-1:0]          signal_index,
    output logic signed [VALUE_W-1:0] signal_value,
    output logic                      last_of_frame
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       ctl_busy;
    logic       cmd_load;
    ctl_cmd_t   cmd_gated;

    // payload bytes, offset zero in the low byte
    logic [63:0] frame_bytes;
    assign frame_bytes = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                          data_byte_3, data_byte_2, data_byte_1, data_byte_0};

    // configuration beats are always taken
    assign cfg_ready = 1'b1;

    // frame beat only when idle
    assign cmd_load        = cmd.load && !ctl_busy;
    assign cmd_gated.load  = cmd_load;
    assign cmd_gated.issue = cmd.issue;
    assign cmd_gated.idx   = cmd.idx;

    ecu_csd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (ctl_busy),
        .status (status),
        .cmd    (cmd)
    );

    ecu_csd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_gated),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .can_id        (can_id),
        .frame_length  (frame_length),
        .frame_bytes   (frame_bytes),
        .result_strobe (result_strobe),
        .signal_index  (signal_index),
        .signal_value  (signal_value),
        .last_of_frame (last_of_frame)
    );

    assign busy = ctl_busy;

endmodule

FILE: tb/tb_top.sv
// testbench for ecu_can_broadcast_signal_decoder: frames go in as start/busy beats and
// every decoded signal is checked against a local table-driven decoder
// depends on ecu_csd_pkg and the decoder rtl, nothing else
module tb_top;
    import ecu_csd_pkg::*;

    localparam int LIMIT_CYCLES  = 100000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 2000;
    localparam int SLOTS         = 11;
    localparam int FRAME_START [SLOTS+1] = '{0, 12, 18, 22, 29, 33, 37, 41, 45, 53, 61, 64};

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [7:0][7:0]  data;
    } frame_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic               last;
    } signal_t;

    typedef struct packed {
        sig_kind_t  kind;
        logic [5:0] pos;
        logic [5:0] mul;
        logic       div3;
        logic       sub40;
    } sig_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start;
    logic                      busy;
    logic [ID_W-1:0]           can_id;
    logic [LEN_W-1:0]          frame_length;
    logic [7:0]                data_byte_0;
    logic [7:0]                data_byte_1;
    logic [7:0]                data_byte_2;
    logic [7:0]                data_byte_3;
    logic [7:0]                data_byte_4;
    logic [7:0]                data_byte_5;
    logic [7:0]                data_byte_6;
    logic [7:0]                data_byte_7;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [ID_W-1:0]           cfg_data;
    logic                      result_strobe;
    logic [IDX_W-1:0]          signal_index;
    logic signed [VALUE_W-1:0] signal_value;
    logic                      last_of_frame;

    // decoder state as the testbench sees it
    logic [ID_W-1:0] active_base = BASE_ID_RESET;
    signal_t         expected_signals [$];
    bit              no_gaps = 1'b0;
    int              cycle_count = 0;
    int              mismatch_count = 0;
    int              frames_sent = 0;
    int              signals_seen = 0;
    int              bases_written = 0;

    ecu_can_broadcast_signal_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .can_id        (can_id),
        .frame_length  (frame_length),
        .data_byte_0   (data_byte_0),
        .data_byte_1   (data_byte_1),
        .data_byte_2   (data_byte_2),
        .data_byte_3   (data_byte_3),
        .data_byte_4   (data_byte_4),
        .data_byte_5   (data_byte_5),
        .data_byte_6   (data_byte_6),
        .data_byte_7   (data_byte_7),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .signal_index  (signal_index),
        .signal_value  (signal_value),
        .last_of_frame (last_of_frame)
    );

    // clock and cycle count
    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d signals still pending",
                 cycle_count, expected_signals.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("cycle %0d mismatch: %s", cycle_count, what);
    endfunction

    function automatic sig_row_t row(sig_kind_t k, int p, int m, bit d3, bit s40);
        sig_row_t r;
        r.kind  = k;
        r.pos   = 6'(p);
        r.mul   = 6'(m);
        r.div3  = d3;
        r.sub40 = s40;
        return r;
    endfunction

    // signal descriptors: type, byte offset (bit number for flags), multiplier,
    // divide by three, minus forty
    function automatic sig_row_t signal_row(int i);
        sig_row_t r;
        case (i)
            // frame 0: two words, eight status flags in byte four, a byte and a word
            0:  r = row(KIND_U16, 0,  1,  0, 0);
            1:  r = row(KIND_U16, 2,  1,  0, 0);
            2:  r = row(KIND_BIT, 32, 1,  0, 0);
            3:  r = row(KIND_BIT, 33, 1,  0, 0);
            4:  r = row(KIND_BIT, 34, 1,  0, 0);
            5:  r = row(KIND_BIT, 35, 1,  0, 0);
            6:  r = row(KIND_BIT, 36, 1,  0, 0);
            7:  r = row(KIND_BIT, 37, 1,  0, 0);
            8:  r = row(KIND_BIT, 38, 1,  0, 0);
            9:  r = row(KIND_BIT, 39, 1,  0, 0);
            10: r = row(KIND_U8,  5,  1,  0, 0);
            11: r = row(KIND_U16, 6,  1,  0, 0);
            // frame 1
            12: r = row(KIND_U16, 0,  1,  0, 0);
            13: r = row(KIND_I16, 2,  2,  0, 0);
            14: r = row(KIND_U8,  4,  50, 0, 0);
            15: r = row(KIND_U8,  5,  50, 0, 0);
            16: r = row(KIND_U8,  6,  1,  0, 0);
            17: r = row(KIND_U8,  7,  1,  0, 0);
            // frame 2
            18: r = row(KIND_I16, 0,  1,  0, 0);
            19: r = row(KIND_I16, 2,  1,  0, 0);
            20: r = row(KIND_I16, 4,  1,  0, 0);
            21: r = row(KIND_I16, 6,  1,  0, 0);
            // frame 3: temperatures carry the minus-forty offset
            22: r = row(KIND_U16, 0,  1,  1, 0);
            23: r = row(KIND_U8,  2,  1,  0, 1);
            24: r = row(KIND_U8,  3,  1,  0, 1);
            25: r = row(KIND_U8,  4,  1,  0, 1);
            26: r = row(KIND_U8,  5,  1,  0, 1);
            27: r = row(KIND_U8,  6,  1,  0, 1);
            28: r = row(KIND_U8,  7,  50, 0, 0);
            // frame 4
            29: r = row(KIND_U16, 2,  1,  1, 0);
            30: r = row(KIND_U8,  4,  1,  0, 1);
            31: r = row(KIND_U8,  5,  1,  0, 1);
            32: r = row(KIND_U16, 6,  1,  0, 0);
            // frame 5
            33: r = row(KIND_U16, 0,  1,  0, 0);
            34: r = row(KIND_U16, 2,  1,  0, 0);
            35: r = row(KIND_U16, 4,  10, 1, 0);
            36: r = row(KIND_U16, 6,  1,  0, 0);
            // frame 6
            37: r = row(KIND_U16, 0,  1,  0, 0);
            38: r = row(KIND_U16, 2,  5,  0, 0);
            39: r = row(KIND_I16, 4,  1,  0, 0);
            40: r = row(KIND_I16, 6,  1,  0, 0);
            // frame 7
            41: r = row(KIND_U16, 0,  1,  0, 0);
            42: r = row(KIND_U16, 2,  1,  0, 0);
            43: r = row(KIND_U16, 4,  1,  1, 0);
            44: r = row(KIND_U16, 6,  1,  0, 0);
            // frame 8
            45: r = row(KIND_I8,  0,  1,  0, 0);
            46: r = row(KIND_I8,  1,  1,  0, 0);
            47: r = row(KIND_I8,  2,  1,  0, 0);
            48: r = row(KIND_I8,  3,  1,  0, 0);
            49: r = row(KIND_I8,  4,  1,  0, 0);
            50: r = row(KIND_I8,  5,  1,  0, 0);
            51: r = row(KIND_I8,  6,  1,  0, 0);
            52: r = row(KIND_I8,  7,  1,  0, 0);
            // frame 9
            53: r = row(KIND_U8,  0,  5,  0, 0);
            54: r = row(KIND_U8,  1,  5,  0, 0);
            55: r = row(KIND_U8,  2,  5,  0, 0);
            56: r = row(KIND_U8,  3,  5,  0, 0);
            57: r = row(KIND_U8,  4,  5,  0, 0);
            58: r = row(KIND_U8,  5,  5,  0, 0);
            59: r = row(KIND_U8,  6,  5,  0, 0);
            60: r = row(KIND_U8,  7,  5,  0, 0);
            // frame 10
            61: r = row(KIND_I8,  0,  1,  0, 0);
            62: r = row(KIND_I8,  1,  1,  0, 0);
            default: r = row(KIND_I8, 2, 1, 0, 0);
        endcase
        return r;
    endfunction

    // decode one frame into the signals it should produce, last one marked
    function automatic void predict_signals(frame_t f);
        signal_t     batch [$];
        sig_row_t    d;
        signal_t     s;
        int          slot;
        int          byte_pos;
        int          need;
        int          raw;
        int          val;
        logic [15:0] word;
        if (f.id < active_base)
            return;
        slot = int'(f.id) - int'(active_base);
        if (slot >= SLOTS)
            return;
        for (int i = FRAME_START[slot]; i < FRAME_START[slot+1]; i++)
        begin
            d        = signal_row(i);
            byte_pos = (d.kind == KIND_BIT) ? int'(d.pos) / 8 : int'(d.pos);
            need     = (d.kind == KIND_U16 || d.kind == KIND_I16) ? 2 : 1;
            // lengths above eight simply cover every byte
            if (int'(f.len) < byte_pos + need)
                continue;
            word = {f.data[byte_pos + ((byte_pos < 7) ? 1 : 0)], f.data[byte_pos]};
            case (d.kind)
                KIND_U8:  raw = int'(word[7:0]);
                KIND_I8:  raw = $signed(word[7:0]);
                KIND_U16: raw = int'(word);
                KIND_I16: raw = $signed(word);
                default:  raw = int'(word[d.pos[2:0]]);
            endcase
            // c-style division truncates toward zero
            val = raw * int'(d.mul);
            if (d.div3)
                val = val / 3;
            if (d.sub40)
                val = val - 40;
            s.idx   = IDX_W'(i);
            s.value = VALUE_W'(val);
            s.last  = 1'b0;
            batch.push_back(s);
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            expected_signals.push_back(batch[k]);
    endfunction

    // result checker: the decoder cannot be held off, so every strobe is a beat
    always @(posedge clk)
    begin
        signal_t want;
        if (rst_n && result_strobe === 1'b1)
        begin
            signals_seen++;
            if (expected_signals.size() == 0)
                note_mismatch($sformatf("idx %0d value %0d last %0b with no signal pending",
                                        signal_index, signal_value, last_of_frame));
            else
            begin
                want = expected_signals.pop_front();
                if (signal_index !== want.idx || signal_value !== want.value
                    || last_of_frame !== want.last)
                    note_mismatch($sformatf(
                        "expected idx %0d value %0d last %0b, got idx %0d value %0d last %0b",
                        want.idx, $signed(want.value), want.last,
                        signal_index, signal_value, last_of_frame));
            end
        end
    end

    // frame builders; slot is relative to the current base and wraps at 11 bits
    function automatic frame_t frame_at(int slot, int len, logic [63:0] data);
        frame_t f;
        f.id   = ID_W'(int'(active_base) + slot);
        f.len  = LEN_W'(len);
        f.data = data;
        return f;
    endfunction

    function automatic logic [63:0] rand_data();
        logic [63:0] d;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 9))
                0:       d[8*i +: 8] = 8'h00;
                1:       d[8*i +: 8] = 8'hFF;
                2:       d[8*i +: 8] = 8'h80;
                3:       d[8*i +: 8] = 8'h7F;
                default: d[8*i +: 8] = 8'($urandom);
            endcase
        end
        return d;
    endfunction

    // mostly frames inside the window, some just outside it, some anywhere
    function automatic frame_t rand_frame();
        int pick;
        int slot;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            slot = $urandom_range(0, SLOTS - 1);
        else if (pick < 90)
            slot = ($urandom_range(0, 1) == 0) ? -1 : SLOTS;
        else
            slot = int'($urandom_range(0, 2047)) - int'(active_base);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            len = 8;
        else if (pick < 85)
            len = $urandom_range(0, 7);
        else
            len = $urandom_range(9, 15);
        return frame_at(slot, len, rand_data());
    endfunction

    // one frame beat: start stays high until busy is seen low at an edge
    task automatic send_frame(frame_t f);
        // idle about one offered cycle in four
        while (!no_gaps && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        can_id       <= f.id;
        frame_length <= f.len;
        data_byte_0  <= f.data[0];
        data_byte_1  <= f.data[1];
        data_byte_2  <= f.data[2];
        data_byte_3  <= f.data[3];
        data_byte_4  <= f.data[4];
        data_byte_5  <= f.data[5];
        data_byte_6  <= f.data[6];
        data_byte_7  <= f.data[7];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        frames_sent++;
        predict_signals(f);
    endtask

    // stop sending, wait for the pending signals, then let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_signals.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        foreach (expected_signals[k])
            note_mismatch($sformatf("idx %0d value %0d last %0b never arrived",
                                    expected_signals[k].idx,
                                    $signed(expected_signals[k].value),
                                    expected_signals[k].last));
        expected_signals.delete();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // base_id write, only with the decoder idle
    task automatic write_base(logic [ID_W-1:0] value);
        settle();
        if (!no_gaps)
            repeat ($urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        active_base = value;
        bases_written++;
    endtask

    // directed frames at the reset base: every frame layout and the field extremes
    task automatic test_reset_base();
        send_frame(frame_at(0, 8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(frame_at(0, 8, 64'h0));
        // status flags present, trailing byte and word cut off
        send_frame(frame_at(0, 5, 64'h0000_00A5_3C00_8001));
        send_frame(frame_at(0, 4, 64'h1234_5678_9ABC_DEF0));
        // most negative i16 doubled reaches the bottom of the value range
        send_frame(frame_at(1, 8, 64'hFFFF_FFFF_8000_0000));
        send_frame(frame_at(2, 8, 64'h7FFF_8000_FFFF_0001));
        send_frame(frame_at(3, 8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(frame_at(3, 8, 64'h0));
        send_frame(frame_at(4, 8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(frame_at(5, 8, 64'hFFFF_FFFF_FFFF_FFFF));
        // word times five reaches the top of the value range
        send_frame(frame_at(6, 8, 64'h8000_7FFF_FFFF_FFFF));
        send_frame(frame_at(7, 7, 64'hEE11_FFFF_0004_0003));
        send_frame(frame_at(8, 8, 64'h8000_7FFF_0180_7F80));
        // length above eight counts as eight
        send_frame(frame_at(9, 15, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(frame_at(10, 1, 64'h0000_0000_0000_0080));
        // empty frame and identifiers just outside and far outside the window
        send_frame(frame_at(0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(frame_at(-1, 8, rand_data()));
        send_frame(frame_at(SLOTS, 8, rand_data()));
        send_frame(frame_at(-int'(active_base), 8, rand_data()));
        send_frame(frame_at(2047 - int'(active_base), 8, rand_data()));
    endtask

    // window at the bottom and top of the identifier space
    task automatic test_window_edges();
        write_base(11'd0);
        send_frame(frame_at(0, 8, rand_data()));
        send_frame(frame_at(10, 8, rand_data()));
        send_frame(frame_at(SLOTS, 8, rand_data()));
        send_frame(frame_at(-1, 8, rand_data()));
        write_base(11'd2037);
        send_frame(frame_at(-1, 8, rand_data()));
        send_frame(frame_at(0, 8, rand_data()));
        send_frame(frame_at(10, 8, rand_data()));
        // window runs past 2047: no wraparound onto low identifiers
        write_base(11'd2045);
        send_frame(frame_at(0, 8, rand_data()));
        send_frame(frame_at(2, 8, rand_data()));
        send_frame(frame_at(3, 8, rand_data()));
        send_frame(frame_at(5, 8, rand_data()));
    endtask

    // back-to-back frames with no gaps at all
    task automatic test_steady_stream();
        write_base(BASE_ID_RESET);
        no_gaps = 1'b1;
        repeat (120) send_frame(rand_frame());
        no_gaps = 1'b0;
    endtask

    // random traffic under a spread of base settings, gaps on
    task automatic test_base_sweep();
        logic [ID_W-1:0] bases [6];
        bases[0] = 11'd0;
        bases[1] = 11'd2037;
        bases[2] = 11'd1023;
        bases[3] = ID_W'($urandom_range(0, 2037));
        bases[4] = ID_W'($urandom_range(0, 2037));
        bases[5] = BASE_ID_RESET;
        foreach (bases[b])
        begin
            write_base(bases[b]);
            repeat (50) send_frame(rand_frame());
        end
    endtask

    // main sequence
    initial
    begin
        start        <= 1'b0;
        can_id       <= '0;
        frame_length <= '0;
        data_byte_0  <= 8'h00;
        data_byte_1  <= 8'h00;
        data_byte_2  <= 8'h00;
        data_byte_3  <= 8'h00;
        data_byte_4  <= 8'h00;
        data_byte_5  <= 8'h00;
        data_byte_6  <= 8'h00;
        data_byte_7  <= 8'h00;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_base();
        test_window_edges();
        test_steady_stream();
        test_base_sweep();
        settle();
        $display("sent %0d frames under %0d base_id writes, checked %0d decoded signals",
                 frames_sent, bases_written, signals_seen);
        $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
